// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL datapath (rtl/iqws_dp.sv).
// Both sample on clk and are disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define CHK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define CHK_IMPL(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

`endif

// ===== rtl/iqws_pkg.sv =====
package iqws_pkg;

  localparam int FIELD_TAG_W = 6;
  localparam int OCC_W       = 5;
  localparam int IW_REG_W    = 4;
  localparam int DW_REG_W    = 5;
  localparam int CFG_DATA_W  = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int IN_DATA_W   = 32;
  localparam int OUT_DATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ISSUE_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISPATCH_WIDTH = 2'd1;

  typedef enum logic [1:0] {
    ACT_DISPATCH,
    ACT_COMPLETE,
    ACT_ISSUE,
    ACT_FLUSH
  } action_t;

  typedef enum logic [1:0] {
    KIND_ACK,
    KIND_ISSUED,
    KIND_NONE,
    KIND_FULL
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DCLR,
    ST_DRD1,
    ST_DRD2,
    ST_COMPL,
    ST_FLUSH,
    ST_SCAN,
    ST_RESP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic  load_in;
    logic  disp_clear;
    logic  disp_src1;
    logic  disp_write;
    logic  complete;
    logic  flush;
    logic  scan_start;
    logic  scan_step;
    logic  resp_load;
    logic  issue_load;
    kind_t resp_kind;
  } cmd_t;

  typedef struct packed {
    logic refuse;
    logic scan_done;
    logic none_issued;
    logic issue_last;
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/issue_queue_wakeup_select_top.sv =====
// Issue queue with wakeup and select.
// Input channel s_*: one item per action. s_tuser carries the action
// (dispatch, completion, issue select, flush); s_tdata carries the operands.
// Output channel m_*: result items, m_tuser the kind, m_tlast on the final
// result of an input item, m_tdata the issued tag and the queue occupancy.
// Configuration: cfg_we with cfg_index 0 sets the issue width, index 1 the
// dispatch width; write only while the block is idle.
// Sequence per item: a dispatch checks for room, clears its own completion
// bit, reads the bitmap for its first and then its second source and appends
// the entry; a refused dispatch goes straight to its full response. A
// completion or flush answers after its single update; an issue select scans
// the queue, then loads one result per selected entry, or one none result.
// The next item is taken only after the last result of this one is loaded.
// The select scan reads one queue slot a cycle from a single read port;
// dispatch reads the completion bitmap once a cycle for its two sources.
// Reset empties the queue and the completion bitmap and sets both widths
// to 2. A stalled receiver holds the output register and the sequencer
// waits; the next input item can still be taken while a result waits.
module issue_queue_wakeup_select_top #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TAG_BITS    = 6,
  parameter int MAX_ISSUE   = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // seq[5:0], src1_producer[11:6], src1_ready[12], src2_producer[18:13],
  // src2_ready[19], is_memory[20], writes_dest[21], mem_issue_limit[27:22]
  input  logic [iqws_pkg::IN_DATA_W-1:0]      s_tdata,
  input  logic [1:0]                          s_tuser,   // action[1:0]
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [iqws_pkg::OUT_DATA_W-1:0]     m_tdata,   // issued_seq[5:0], occupancy[10:6]
  output logic [1:0]                          m_tuser,   // kind[1:0]
  output logic                                m_tlast,
  input  logic                                cfg_we,
  input  logic [iqws_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [iqws_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import iqws_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  iqws_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .stat     (stat),
    .cmd      (cmd)
  );

  iqws_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_BITS    (TAG_BITS),
    .MAX_ISSUE   (MAX_ISSUE)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// ===== rtl/iqws_ctrl.sv =====
module iqws_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [1:0]              s_tuser,
  input  iqws_pkg::stat_t         stat,
  output iqws_pkg::cmd_t          cmd
);
  import iqws_pkg::*;

  state_t state, state_next;
  kind_t  kind_q, kind_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      kind_q <= KIND_ACK;
    end else begin
      state  <= state_next;
      kind_q <= kind_next;
    end
  end

  always_comb begin
    state_next    = state;
    kind_next     = kind_q;
    cmd           = '0;
    cmd.resp_kind = kind_q;
    s_tready      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load_in    = 1'b1;
          cmd.scan_start = 1'b1;
          kind_next      = KIND_ACK;
          unique case (action_t'(s_tuser))
            ACT_DISPATCH: state_next = ST_DCLR;
            ACT_COMPLETE: state_next = ST_COMPL;
            ACT_ISSUE:    state_next = ST_SCAN;
            ACT_FLUSH:    state_next = ST_FLUSH;
            default:      state_next = ST_IDLE;
          endcase
        end
      end
      ST_DCLR: begin
        if (stat.refuse) begin
          kind_next  = KIND_FULL;
          state_next = ST_RESP;
        end else begin
          cmd.disp_clear = 1'b1;
          state_next     = ST_DRD1;
        end
      end
      ST_DRD1: begin
        cmd.disp_src1 = 1'b1;
        state_next    = ST_DRD2;
      end
      ST_DRD2: begin
        cmd.disp_write = 1'b1;
        state_next     = ST_RESP;
      end
      ST_COMPL: begin
        cmd.complete = 1'b1;
        state_next   = ST_RESP;
      end
      ST_FLUSH: begin
        cmd.flush  = 1'b1;
        state_next = ST_RESP;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) begin
          if (stat.none_issued) begin
            kind_next  = KIND_NONE;
            state_next = ST_RESP;
          end else begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_RESP: begin
        if (stat.out_free) begin
          cmd.resp_load = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.issue_load = 1'b1;
          if (stat.issue_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/iqws_dp.sv =====
`include "assert_macros.svh"

module iqws_dp #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TAG_BITS    = 6,
  parameter int MAX_ISSUE   = 8
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic [iqws_pkg::IN_DATA_W-1:0]         s_tdata,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [iqws_pkg::OUT_DATA_W-1:0]        m_tdata,
  output logic [1:0]                             m_tuser,
  output logic                                   m_tlast,
  input  logic                                   cfg_we,
  input  logic [iqws_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [iqws_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  iqws_pkg::cmd_t                         cmd,
  output iqws_pkg::stat_t                        stat
);
  import iqws_pkg::*;

  localparam int IW       = $clog2(QUEUE_DEPTH);
  localparam int CW       = $clog2(QUEUE_DEPTH + 1);
  localparam int NW       = $clog2(MAX_ISSUE + 1);
  localparam int KW       = (MAX_ISSUE > 1) ? $clog2(MAX_ISSUE) : 1;
  localparam int MAP_SIZE = 1 << TAG_BITS;

  typedef struct packed {
    logic [TAG_BITS-1:0] seq;
    logic [TAG_BITS-1:0] p1;
    logic [TAG_BITS-1:0] p2;
    logic                r1;
    logic                r2;
    logic                mem;
  } entry_t;

  entry_t               entries [QUEUE_DEPTH];
  logic [TAG_BITS-1:0]  tags [MAX_ISSUE];
  logic [MAP_SIZE-1:0]  cmap;
  logic [CW-1:0]        count;
  logic [IW_REG_W-1:0]  iss_cfg;
  logic [DW_REG_W-1:0]  disp_cfg;

  logic [TAG_BITS-1:0]  seq_q, p1_q, p2_q, lim_q;
  logic                 r1_q, r2_q, mem_q, wd_q;

  logic [CW-1:0]        scan_i, scan_w;
  logic [NW-1:0]        scan_n, emit_k, width_eff, k_plus;
  entry_t               cur;
  logic                 can_go;

  logic                 out_valid, out_last;
  kind_t                out_kind;
  logic [FIELD_TAG_W-1:0] out_tag;
  logic [OCC_W-1:0]     out_occ;

  always_comb begin
    if (iss_cfg == '0) begin
      width_eff = NW'(1);
    end else if (32'(iss_cfg) > MAX_ISSUE) begin
      width_eff = NW'(MAX_ISSUE);
    end else begin
      width_eff = NW'(iss_cfg);
    end
  end

  assign cur    = entries[scan_i[IW-1:0]];
  assign can_go = cur.r1 && cur.r2 && (!cur.mem || (cur.seq <= lim_q));
  assign k_plus = emit_k + NW'(1);

  assign stat.refuse      = (32'(count) >= QUEUE_DEPTH) ||
                            (32'(count) + 32'(disp_cfg) > QUEUE_DEPTH);
  assign stat.scan_done   = (scan_i == count);
  assign stat.none_issued = (scan_n == '0);
  assign stat.issue_last  = (k_plus == scan_n);
  assign stat.out_free    = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      iss_cfg  <= IW_REG_W'(2);
      disp_cfg <= DW_REG_W'(2);
    end else if (cfg_we) begin
      if (cfg_index == CFG_ISSUE_WIDTH) begin
        iss_cfg <= cfg_data[IW_REG_W-1:0];
      end else if (cfg_index == CFG_DISPATCH_WIDTH) begin
        disp_cfg <= cfg_data[DW_REG_W-1:0];
      end
    end
  end

  // Input fields; tags are cut or widened to the internal tag width.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      seq_q <= TAG_BITS'(s_tdata[5:0]);
      p1_q  <= TAG_BITS'(s_tdata[11:6]);
      r1_q  <= s_tdata[12];
      p2_q  <= TAG_BITS'(s_tdata[18:13]);
      r2_q  <= s_tdata[19];
      mem_q <= s_tdata[20];
      wd_q  <= s_tdata[21];
      lim_q <= TAG_BITS'(s_tdata[27:22]);
    end else if (cmd.disp_src1) begin
      r1_q <= r1_q | cmap[p1_q];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmap  <= '0;
      count <= '0;
    end else if (cmd.flush) begin
      cmap  <= '0;
      count <= '0;
    end else if (cmd.disp_clear) begin
      cmap[seq_q] <= 1'b0;
    end else if (cmd.disp_write) begin
      count <= count + CW'(1);
    end else if (cmd.complete) begin
      cmap[seq_q] <= 1'b1;
    end else if (cmd.scan_step && stat.scan_done) begin
      count <= scan_w;
    end
  end

  // Queue storage: dispatch append, tag-match wakeup on every slot, and the
  // compacting copy of the select scan.
  always_ff @(posedge clk) begin
    if (cmd.disp_write) begin
      entries[count[IW-1:0]] <= '{seq: seq_q, p1: p1_q, p2: p2_q, r1: r1_q,
                                  r2: r2_q | cmap[p2_q], mem: mem_q};
    end else if (cmd.complete && wd_q) begin
      for (int j = 0; j < QUEUE_DEPTH; j++) begin
        if (entries[j].p1 == seq_q) entries[j].r1 <= 1'b1;
        if (entries[j].p2 == seq_q) entries[j].r2 <= 1'b1;
      end
    end else if (cmd.scan_step && !stat.scan_done &&
                 !((scan_n < width_eff) && can_go)) begin
      entries[scan_w[IW-1:0]] <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_i <= '0;
      scan_w <= '0;
      scan_n <= '0;
      emit_k <= '0;
    end else if (cmd.scan_start) begin
      scan_i <= '0;
      scan_w <= '0;
      scan_n <= '0;
      emit_k <= '0;
    end else if (cmd.scan_step && !stat.scan_done) begin
      scan_i <= scan_i + CW'(1);
      if ((scan_n < width_eff) && can_go) begin
        scan_n <= scan_n + NW'(1);
      end else begin
        scan_w <= scan_w + CW'(1);
      end
    end else if (cmd.issue_load) begin
      emit_k <= k_plus;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step && !stat.scan_done && (scan_n < width_eff) && can_go) begin
      tags[scan_n[KW-1:0]] <= cur.seq;
    end
  end

  // Output register; the queue side keeps working while a result waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.resp_load || cmd.issue_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resp_load) begin
      out_kind <= cmd.resp_kind;
      out_tag  <= '0;
      out_last <= 1'b1;
      out_occ  <= OCC_W'(count);
    end else if (cmd.issue_load) begin
      out_kind <= KIND_ISSUED;
      out_tag  <= FIELD_TAG_W'(tags[emit_k[KW-1:0]]);
      out_last <= stat.issue_last;
      out_occ  <= OCC_W'(count);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;
  assign m_tdata  = {{(OUT_DATA_W - FIELD_TAG_W - OCC_W){1'b0}}, out_occ, out_tag};

  `CHK(a_count_range, 32'(count) <= QUEUE_DEPTH, "queue count exceeds depth")
  `CHK(a_compact_order, scan_w <= scan_i, "compaction write passed the read")
  `CHK_IMPL(a_issue_bound, cmd.scan_step && !stat.scan_done,
            scan_n <= width_eff, "more entries selected than the issue width")

endmodule

// ===== bench/issue_queue_wakeup_select_checker.sv =====
module issue_queue_wakeup_select_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,
  input  logic [1:0]  m_tuser,
  input  logic        m_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data,
  output int          mismatches,
  output int          pending
);
  import iqws_pkg::*;

  typedef struct packed {
    logic [5:0] seq;
    logic [5:0] p1;
    logic [5:0] p2;
    logic       r1;
    logic       r2;
    logic       mem;
  } slot_t;

  typedef struct packed {
    kind_t      kind;
    logic [5:0] tag;
    logic       last;
    logic [4:0] occ;
  } result_t;

  slot_t      q[16];
  int         count;
  logic [63:0] done_map;
  logic [3:0] iw;
  logic [4:0] dw;
  result_t    results_due[$];

  assign pending = results_due.size();

  task automatic queue_result(kind_t k, logic [5:0] t, logic l);
    result_t r;
    r.kind = k; r.tag = t; r.last = l; r.occ = count[4:0];
    results_due = {results_due, r};
  endtask

  task automatic predict_item(action_t act, logic [31:0] d);
    slot_t e;
    logic [5:0] seq;
    logic [5:0] tags[8];
    int n, w, width;
    seq = d[5:0];
    n = 0;
    w = 0;
    case (act)
      ACT_DISPATCH: begin
        if (count >= 16 || count + dw > 16) begin
          queue_result(KIND_FULL, 0, 1);
        end else begin
          e.seq = seq; e.p1 = d[11:6]; e.r1 = d[12];
          e.p2 = d[18:13]; e.r2 = d[19]; e.mem = d[20];
          done_map[seq] = 1'b0;
          if (done_map[e.p1]) e.r1 = 1'b1;
          if (done_map[e.p2]) e.r2 = 1'b1;
          q[count] = e;
          count++;
          queue_result(KIND_ACK, 0, 1);
        end
      end
      ACT_COMPLETE: begin
        done_map[seq] = 1'b1;
        if (d[21]) begin
          for (int i = 0; i < count; i++) begin
            if (q[i].p1 == seq) q[i].r1 = 1'b1;
            if (q[i].p2 == seq) q[i].r2 = 1'b1;
          end
        end
        queue_result(KIND_ACK, 0, 1);
      end
      ACT_ISSUE: begin
        width = (iw == 0) ? 1 : (iw > 8 ? 8 : iw);
        for (int i = 0; i < count; i++) begin
          if (n < width && q[i].r1 && q[i].r2 && (!q[i].mem || q[i].seq <= d[27:22])) begin
            tags[n] = q[i].seq;
            n++;
          end else begin
            q[w] = q[i];
            w++;
          end
        end
        count = w;
        if (n == 0) queue_result(KIND_NONE, 0, 1);
        for (int k = 0; k < n; k++) queue_result(KIND_ISSUED, tags[k], k == n - 1);
      end
      default: begin
        count = 0;
        done_map = '0;
        queue_result(KIND_ACK, 0, 1);
      end
    endcase
  endtask

  always @(posedge clk) begin
    result_t got, want;
    if (rst) begin
      count = 0;
      done_map = '0;
      iw = 4'd2;
      dw = 5'd2;
      mismatches = 0;
      results_due.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_ISSUE_WIDTH) iw = cfg_data[3:0];
        else if (cfg_index == CFG_DISPATCH_WIDTH) dw = cfg_data;
      end
      if (m_tvalid && m_tready) begin
        got.kind = kind_t'(m_tuser); got.tag = m_tdata[5:0];
        got.last = m_tlast; got.occ = m_tdata[10:6];
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result kind=%0d tag=%0d", got.kind, got.tag);
        end else begin
          want = results_due.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: want kind=%0d tag=%0d last=%0d occ=%0d, got %0d %0d %0d %0d",
                       want.kind, want.tag, want.last, want.occ,
                       got.kind, got.tag, got.last, got.occ);
          end
        end
      end
      if (s_tvalid && s_tready) predict_item(action_t'(s_tuser), s_tdata);
    end
  end
endmodule

// ===== bench/issue_queue_wakeup_select_top_tb.sv =====
module issue_queue_wakeup_select_top_tb;
  import iqws_pkg::*;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [15:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_we = 0;
  logic [1:0]  cfg_index = '0;
  logic [4:0]  cfg_data = '0;
  int          mismatches;
  int          pending;
  int          idle_cycles = 0;
  bit          hold_off = 0;
  logic [5:0]  next_tag = 0;

  always #10 clk = ~clk;

  issue_queue_wakeup_select_top dut (.*);

  issue_queue_wakeup_select_checker chk (.*);

  // Receiver: random stalls, and one long blackout once hold_off is raised.
  initial begin
    int n;
    bit held;
    held = 0;
    forever begin
      @(negedge clk);
      if (hold_off && !held) begin
        held = 1;
        m_tready <= 1'b0;
        repeat (200) @(negedge clk);
      end
      n = $urandom_range(0, 99);
      m_tready <= (n < 85);
      if (n >= 97) begin
        repeat ($urandom_range(10, 40)) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send(action_t act, logic [31:0] d);
    s_tuser <= act;
    s_tdata <= d;
    s_tvalid <= 1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    if ($urandom_range(0, 3) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(5, 30) : $urandom_range(1, 3))
        @(negedge clk);
    end
  endtask

  task automatic drain;
    s_tvalid <= 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [4:0] v);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  // Dispatch fields: mostly fresh tags with producers among recent tags.
  function automatic logic [31:0] dispatch_data(bit rnd);
    logic [31:0] d;
    d = $urandom;
    d[31:28] = '0;
    if (!rnd) begin
      d[5:0] = next_tag;
      d[11:6] = 6'(next_tag - $urandom_range(1, 6));
      d[18:13] = 6'(next_tag - $urandom_range(1, 6));
    end
    return d;
  endfunction

  task automatic random_item(bit sane);
    int r;
    logic [31:0] d;
    r = $urandom_range(0, 99);
    d = $urandom;
    d[31:28] = '0;
    if (r < 45) begin
      send(ACT_DISPATCH, dispatch_data(!sane));
      next_tag++;
    end else if (r < 70) begin
      if (sane) d[5:0] = 6'(next_tag - $urandom_range(1, 8));
      send(ACT_COMPLETE, d);
    end else if (r < 97) begin
      send(ACT_ISSUE, d);
    end else begin
      send(ACT_FLUSH, d);
    end
  endtask

  initial begin
    logic [31:0] d;
    repeat (6) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    // Directed: ready and waiting sources, memory ordering, full refusal.
    send(ACT_ISSUE, 32'h0);
    send(ACT_DISPATCH, {4'h0, 6'd0, 1'b0, 1'b0, 1'b1, 6'd0, 1'b1, 6'd0, 6'd1});
    send(ACT_DISPATCH, {4'h0, 6'd0, 1'b0, 1'b1, 1'b0, 6'd1, 1'b0, 6'd1, 6'd2});
    send(ACT_DISPATCH, {4'h0, 6'd0, 1'b0, 1'b0, 1'b1, 6'd63, 1'b1, 6'd63, 6'd63});
    send(ACT_ISSUE, {4'h0, 6'd0, 22'h0});
    send(ACT_ISSUE, {4'h0, 6'd63, 22'h0});
    send(ACT_COMPLETE, {4'h0, 6'd0, 1'b0, 21'd1});
    send(ACT_COMPLETE, {4'h0, 6'd0, 1'b1, 21'd1});
    send(ACT_DISPATCH, {4'h0, 6'd0, 1'b0, 1'b0, 1'b0, 6'd1, 1'b0, 6'd1, 6'd3});
    send(ACT_DISPATCH, {4'h0, 6'd0, 1'b0, 1'b0, 1'b1, 6'd3, 1'b1, 6'd5, 6'd3});
    send(ACT_ISSUE, {4'h0, 6'd63, 22'h0});
    for (int i = 0; i < 16; i++) send(ACT_DISPATCH, dispatch_data(1));
    send(ACT_FLUSH, 32'h0);
    drain();
    write_cfg(CFG_ISSUE_WIDTH, 5'd8);
    write_cfg(CFG_DISPATCH_WIDTH, 5'd1);
    // Fill while the receiver is held off, so the input stalls.
    hold_off = 1;
    for (int i = 0; i < 20; i++) begin
      d = dispatch_data(0);
      d[12] = 1'b1; d[19] = 1'b1;
      send(ACT_DISPATCH, d);
      next_tag++;
    end
    send(ACT_ISSUE, 32'h0fc0_0000);
    send(ACT_ISSUE, 32'h0fc0_0000);
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_cfg(CFG_ISSUE_WIDTH, 5'd0); write_cfg(CFG_DISPATCH_WIDTH, 5'd16); end
        1: begin write_cfg(CFG_ISSUE_WIDTH, 5'd15); write_cfg(CFG_DISPATCH_WIDTH, 5'd17); end
        2: begin write_cfg(CFG_ISSUE_WIDTH, 5'd1); write_cfg(CFG_DISPATCH_WIDTH, 5'd31); end
        3: begin write_cfg(CFG_ISSUE_WIDTH, 5'd3); write_cfg(CFG_DISPATCH_WIDTH, 5'd0); end
        default: begin
          write_cfg(CFG_ISSUE_WIDTH, 5'($urandom_range(1, 8)));
          write_cfg(CFG_DISPATCH_WIDTH, 5'($urandom_range(1, 4)));
        end
      endcase
      write_cfg(2'd3, 5'($urandom));
      for (int i = 0; i < 45; i++) random_item($urandom_range(0, 9) < 8);
      drain();
    end
    if (mismatches == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// ===== issue_queue_wakeup_select_top.f =====
+incdir+rtl
rtl/iqws_pkg.sv
rtl/iqws_ctrl.sv
rtl/iqws_dp.sv
rtl/issue_queue_wakeup_select_top.sv
bench/issue_queue_wakeup_select_checker.sv
bench/issue_queue_wakeup_select_top_tb.sv
